// ===== rtl/core/hck_pkg.sv =====
// ----------------------------------------------------------------------------
// hck_pkg
// Types and constants shared by the HSV color key and median mask block.
// ----------------------------------------------------------------------------
package hck_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd0;
	localparam logic [2:0] CFG_FRAME_HEIGHT   = 3'd1;
	localparam logic [2:0] CFG_GREEN_HUE_LOW  = 3'd2;
	localparam logic [2:0] CFG_GREEN_HUE_HIGH = 3'd3;
	localparam logic [2:0] CFG_RED_HUE_HIGH   = 3'd4;
	localparam logic [2:0] CFG_RED_WRAP_LOW   = 3'd5;
	localparam logic [2:0] CFG_SAT_MIN        = 3'd6;
	localparam logic [2:0] CFG_VAL_MIN        = 3'd7;

	// register reset values
	localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
	localparam logic [7:0]  RST_GREEN_LOW    = 8'd47;
	localparam logic [7:0]  RST_GREEN_HIGH   = 8'd67;
	localparam logic [7:0]  RST_RED_HIGH     = 8'd8;
	localparam logic [7:0]  RST_RED_WRAP_LOW = 8'd170;
	localparam logic [7:0]  RST_SAT_MIN      = 8'd20;
	localparam logic [7:0]  RST_VAL_MIN      = 8'd15;

	// fixed color limits
	localparam logic [7:0] VALUE_MAX    = 8'd200;
	localparam logic [8:0] HUE_WRAP_TOP = 9'd180;

	// line ring
	localparam int RING_BITS = 3;

	// position counters follow the 11-bit width and height registers
	localparam int POS_W = 11;

	typedef struct packed {
		logic       command;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic mask_bit;
		logic last_of_frame;
	} mask_t;

	typedef struct packed {
		logic [7:0] green_lo;
		logic [7:0] green_hi;
		logic [7:0] red_hi;
		logic [7:0] red_wrap_lo;
		logic [7:0] sat_min;
		logic [7:0] val_min;
	} hue_cfg_t;

	// mark write into the line ring
	typedef struct packed {
		logic                 en;
		logic [RING_BITS-1:0] row;
		logic [POS_W-1:0]     col;
		logic                 mark;
	} ring_wr_t;

	// window scan request: center and last valid row and column
	typedef struct packed {
		logic [POS_W-1:0] orow;
		logic [POS_W-1:0] ocol;
		logic [POS_W-1:0] wlast;
		logic [POS_W-1:0] hlast;
	} scan_req_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_SAT,
		C_HUE,
		C_DONE
	} cls_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_CLASS,
		T_POST,
		T_DIV,
		T_SCAN,
		T_EMIT
	} top_state_t;

endpackage

// ===== rtl/core/hck_divider.sv =====
// ----------------------------------------------------------------------------
// hck_divider
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module hck_divider #(
	parameter int NW = 18,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	// one trial subtraction per step
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/core/hck_classify.sv =====
// ----------------------------------------------------------------------------
// hck_classify
// RGB to HSV and band test for one pixel, using one serial divider for
// saturation and then hue.
// ----------------------------------------------------------------------------
module hck_classify (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  hck_pkg::hue_cfg_t cfg,
	output logic              done,
	output logic              mark
);

	import hck_pkg::*;

	localparam int NW = 18;
	localparam int DW = 9;

	cls_state_t    state_q, state_n;
	logic [7:0]    v_in, mn_in, diff_in;
	logic [11:0]   x_in;
	logic [7:0]    v_q, diff_q, s_q, h_q;
	logic [11:0]   x_q;
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den, div_rem;
	logic [8:0]    hq;

	// max, min and shifted hue numerator; red wins ties, then green
	always_comb begin
		v_in = red;
		if (green > v_in) v_in = green;
		if (blue > v_in) v_in = blue;
		mn_in = red;
		if (green < mn_in) mn_in = green;
		if (blue < mn_in) mn_in = blue;
		diff_in = v_in - mn_in;
		if (v_in == red)
			x_in = 12'(green) + 12'(diff_in) * 12'd6 - 12'(blue);
		else if (v_in == green)
			x_in = 12'(blue) + 12'(diff_in) * 12'd8 - 12'(red);
		else
			x_in = 12'(red) + 12'(diff_in) * 12'd10 - 12'(green);
	end

	// divider operands: saturation first, hue second
	always_comb begin
		if (state_q == C_IDLE) begin
			div_num = 18'({diff_in, 8'b0}) - 18'(diff_in) + 18'(v_in[7:1]);
			div_den = 9'(v_in);
		end else begin
			div_num = 18'({x_q, 6'b0}) - 18'({x_q, 2'b0}) + 18'(diff_q);
			div_den = {diff_q, 1'b0};
		end
	end

	hck_divider #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			C_IDLE: if (start) state_n = (v_in != 8'd0) ? C_SAT : C_DONE;
			C_SAT:  if (div_done) state_n = (diff_q != 8'd0) ? C_HUE : C_DONE;
			C_HUE:  if (div_done) state_n = C_DONE;
			C_DONE: state_n = C_IDLE;
			default: state_n = C_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		div_start = ((state_q == C_IDLE) && start && (v_in != 8'd0))
			|| ((state_q == C_SAT) && div_done && (diff_q != 8'd0));
		done = state_q == C_DONE;
		mark = 1'b0;
		if (s_q >= cfg.sat_min && v_q >= cfg.val_min && v_q <= VALUE_MAX) begin
			if (h_q >= cfg.green_lo && h_q <= cfg.green_hi) mark = 1'b1;
			if (h_q <= cfg.red_hi) mark = 1'b1;
			if (h_q >= cfg.red_wrap_lo && 9'(h_q) <= HUE_WRAP_TOP) mark = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_n;
	end

	// rounded hue, folded into 0..179
	assign hq = div_quo[8:0];

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			v_q    <= v_in;
			diff_q <= diff_in;
			x_q    <= x_in;
			s_q    <= '0;
			h_q    <= '0;
		end
		if (state_q == C_SAT && div_done) s_q <= div_quo[7:0];
		if (state_q == C_HUE && div_done)
			h_q <= (hq >= HUE_WRAP_TOP) ? 8'(hq - HUE_WRAP_TOP) : hq[7:0];
	end

	logic unused_rem;
	assign unused_rem = ^div_rem;

endmodule

// ===== rtl/core/hck_window.sv =====
// ----------------------------------------------------------------------------
// hck_window
// Ring of mark lines in one synchronous memory, plus the window scan that
// reads the KxK neighborhood one entry per cycle and takes the majority.
// ----------------------------------------------------------------------------
module hck_window #(
	parameter int MAX_LINE_WIDTH = 1024,
	parameter int KERNEL_SIZE    = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hck_pkg::ring_wr_t  wr,
	input  logic               scan_start,
	input  hck_pkg::scan_req_t req,
	output logic               scan_done,
	output logic               majority
);

	import hck_pkg::*;

	localparam int DEPTH  = (1 << RING_BITS) * MAX_LINE_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int RAD    = KERNEL_SIZE / 2;
	localparam int KW     = $clog2(KERNEL_SIZE);
	localparam int THRESH = (KERNEL_SIZE * KERNEL_SIZE + 1) / 2;
	localparam int NW_CNT = $clog2(KERNEL_SIZE * KERNEL_SIZE + 1);

	logic              mem [DEPTH];
	scan_req_t         req_q;
	logic              issue_q;
	logic [KW-1:0]     dr_q, dc_q;
	logic              last_tap;
	logic signed [12:0] rs, cs;
	logic [POS_W-1:0]  rr, cc;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic              rd_data_s1, rd_vld_s1, rd_last_s1;
	logic [NW_CNT-1:0] cnt_q;
	logic [NW_CNT-1:0] cnt_sum;
	logic              done_q, maj_q;

	// clamped tap position (replicated borders)
	always_comb begin
		rs = 13'(req_q.orow) + 13'(dr_q) - 13'(RAD);
		cs = 13'(req_q.ocol) + 13'(dc_q) - 13'(RAD);
		if (rs < 0) rr = '0;
		else if (rs > $signed(13'(req_q.hlast))) rr = req_q.hlast;
		else rr = rs[POS_W-1:0];
		if (cs < 0) cc = '0;
		else if (cs > $signed(13'(req_q.wlast))) cc = req_q.wlast;
		else cc = cs[POS_W-1:0];
		rd_addr  = AW'(rr[RING_BITS-1:0] * MAX_LINE_WIDTH + cc);
		wr_addr  = AW'(wr.row * MAX_LINE_WIDTH + wr.col);
		last_tap = (dr_q == KW'(KERNEL_SIZE - 1)) && (dc_q == KW'(KERNEL_SIZE - 1));
		cnt_sum  = cnt_q + NW_CNT'(rd_data_s1);
	end

	// line ring memory
	always_ff @(posedge clk) begin
		if (wr.en) mem[wr_addr] <= wr.mark;
		if (issue_q) rd_data_s1 <= mem[rd_addr];
	end

	// tap sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= 1'b0;
			dr_q       <= '0;
			dc_q       <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			rd_vld_s1  <= issue_q;
			rd_last_s1 <= issue_q && last_tap;
			if (scan_start) begin
				issue_q <= 1'b1;
				dr_q    <= '0;
				dc_q    <= '0;
				cnt_q   <= '0;
			end else begin
				if (issue_q) begin
					if (dc_q == KW'(KERNEL_SIZE - 1)) begin
						dc_q <= '0;
						dr_q <= dr_q + 1'b1;
					end else begin
						dc_q <= dc_q + 1'b1;
					end
					if (last_tap) issue_q <= 1'b0;
				end
				if (rd_vld_s1) cnt_q <= cnt_sum;
				if (rd_last_s1) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) req_q <= req;
		if (rd_last_s1) maj_q <= cnt_sum >= NW_CNT'(THRESH);
	end

	assign scan_done = done_q;
	assign majority  = maj_q;

endmodule

// ===== rtl/core/hsv_color_key_median_mask.sv =====
// ----------------------------------------------------------------------------
// hsv_color_key_median_mask
// RGB pixel stream to HSV color key marks, filtered by a KxK binary median
// over a ring of mark lines; one mask beat per item once the window is full.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A flush tick is ignored while the item
// count is zero; a pixel runs up to two 18-step serial divides, one when max
// equals min and none when black. An item that yields a beat also runs the
// output position divide and the line ring reads, and waits while the output
// is stalled. Latency of a beat: RAD*W+RAD items (2*W+2 by default) after its
// pixel. Reset: counters, control and registers return to defaults; ring kept.
module hsv_color_key_median_mask #(
	parameter int MAX_LINE_WIDTH = 1024,
	parameter int KERNEL_SIZE    = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_stall,
	input  hck_pkg::pix_t  pix,
	output logic           mask_valid,
	input  logic           mask_stall,
	output hck_pkg::mask_t mask,
	input  logic           cfg_wr_en,
	input  logic [2:0]     cfg_index,
	input  logic [10:0]    cfg_data
);

	import hck_pkg::*;

	localparam int RAD     = KERNEL_SIZE / 2;
	localparam int WMAX    = (MAX_LINE_WIDTH < 2047) ? MAX_LINE_WIDTH : 2047;
	localparam int OCW     = $clog2(WMAX * 2047 + 1);
	localparam int LAT_MAX = RAD * WMAX + RAD;
	localparam int IW      = $clog2(LAT_MAX + 1);

	// configuration registers
	logic [10:0] frame_width_q, frame_height_q;
	hue_cfg_t    hue_q;

	top_state_t       state_q, state_n;
	logic [POS_W-1:0] col_q, row_q, col_w, row_w;
	logic [POS_W:0]   col_inc;
	logic [OCW-1:0]   oc_q, total_q;
	logic [IW-1:0]    item_q, lat;
	logic [POS_W-1:0] eff_w, eff_h;
	logic             accept, item_early, is_last;
	logic             cls_start, cls_done, cls_mark;
	logic             div_start, div_done;
	logic [OCW-1:0]   div_quo;
	logic [POS_W-1:0] div_rem;
	logic             scan_start, scan_done, majority;
	ring_wr_t         wr;
	scan_req_t        req;
	logic             mask_q, out_load;
	logic             out_valid_q;
	mask_t            out_q;

	// effective frame size
	always_comb begin
		if (frame_width_q == '0) eff_w = 11'd1;
		else if (32'(frame_width_q) > MAX_LINE_WIDTH) eff_w = 11'(MAX_LINE_WIDTH);
		else eff_w = frame_width_q;
		eff_h      = (frame_height_q == '0) ? 11'd1 : frame_height_q;
		lat        = IW'(32'(eff_w) * RAD + RAD);
		item_early = item_q < lat;
		is_last    = ({1'b0, oc_q} + 1'b1) >= {1'b0, total_q};
	end

	// position of the incoming pixel after the stale-column wrap
	always_comb begin
		col_w = col_q;
		row_w = row_q;
		if (col_q >= eff_w) begin
			col_w = '0;
			row_w = row_q + 1'b1;
		end
		col_inc = {1'b0, col_q} + 1'b1;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= RST_FRAME_WIDTH;
			frame_height_q    <= RST_FRAME_HEIGHT;
			hue_q.green_lo    <= RST_GREEN_LOW;
			hue_q.green_hi    <= RST_GREEN_HIGH;
			hue_q.red_hi      <= RST_RED_HIGH;
			hue_q.red_wrap_lo <= RST_RED_WRAP_LOW;
			hue_q.sat_min     <= RST_SAT_MIN;
			hue_q.val_min     <= RST_VAL_MIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:    frame_width_q     <= cfg_data;
				CFG_FRAME_HEIGHT:   frame_height_q    <= cfg_data;
				CFG_GREEN_HUE_LOW:  hue_q.green_lo    <= cfg_data[7:0];
				CFG_GREEN_HUE_HIGH: hue_q.green_hi    <= cfg_data[7:0];
				CFG_RED_HUE_HIGH:   hue_q.red_hi      <= cfg_data[7:0];
				CFG_RED_WRAP_LOW:   hue_q.red_wrap_lo <= cfg_data[7:0];
				CFG_SAT_MIN:        hue_q.sat_min     <= cfg_data[7:0];
				CFG_VAL_MIN:        hue_q.val_min     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// frame size product, registered from the size registers
	always_ff @(posedge clk) begin
		total_q <= OCW'(eff_w * eff_h);
	end

	hck_classify u_cls (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cls_start),
		.red   (pix.red),
		.green (pix.green),
		.blue  (pix.blue),
		.cfg   (hue_q),
		.done  (cls_done),
		.mark  (cls_mark)
	);

	// output position: row and column of the next beat
	hck_divider #(
		.NW(OCW),
		.DW(POS_W)
	) u_pos_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (oc_q),
		.den   (eff_w),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	always_comb begin
		req.orow  = div_quo[POS_W-1:0];
		req.ocol  = div_rem;
		req.wlast = eff_w - 1'b1;
		req.hlast = eff_h - 1'b1;
	end

	hck_window #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH),
		.KERNEL_SIZE   (KERNEL_SIZE)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.scan_start(scan_start),
		.req       (req),
		.scan_done (scan_done),
		.majority  (majority)
	);

	assign accept = pix_valid && !pix_stall;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (accept) begin
					if (pix.command && item_q == '0) state_n = T_IDLE;
					else if (!pix.command && row_w < eff_h) state_n = T_CLASS;
					else state_n = T_POST;
				end
			end
			T_CLASS: if (cls_done) state_n = T_POST;
			T_POST:  state_n = item_early ? T_IDLE : T_DIV;
			T_DIV:   if (div_done) state_n = T_SCAN;
			T_SCAN:  if (scan_done) state_n = T_EMIT;
			T_EMIT:  if (out_load) state_n = T_IDLE;
			default: state_n = T_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pix_stall  = state_q != T_IDLE;
		cls_start  = (state_q == T_IDLE) && accept && !pix.command && (row_w < eff_h);
		div_start  = (state_q == T_POST) && !item_early;
		scan_start = (state_q == T_DIV) && div_done;
		out_load   = (state_q == T_EMIT) && !(out_valid_q && mask_stall);
		wr.en      = (state_q == T_CLASS) && cls_done;
		wr.row     = row_q[RING_BITS-1:0];
		wr.col     = col_q;
		wr.mark    = cls_mark;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			oc_q    <= '0;
			item_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == T_IDLE && accept && !pix.command) begin
				col_q <= col_w;
				row_q <= row_w;
			end
			if (wr.en) begin
				if (col_inc >= {1'b0, eff_w}) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_inc[POS_W-1:0];
				end
			end
			// item count saturates at or above the largest latency
			if (state_q == T_POST && item_q != '1) item_q <= item_q + 1'b1;
			if (out_load) begin
				if (is_last) begin
					col_q  <= '0;
					row_q  <= '0;
					oc_q   <= '0;
					item_q <= '0;
				end else begin
					oc_q <= oc_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!mask_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (scan_done) mask_q <= majority;
		if (out_load) begin
			out_q.mask_bit      <= mask_q;
			out_q.last_of_frame <= is_last;
		end
	end

	assign mask_valid = out_valid_q;
	assign mask       = out_q;

endmodule
